// File: sv/packbits_rle_decoder_assert.svh
// Assertion macros for the PackBits decoder.
`ifndef PACKBITS_RLE_DECODER_ASSERT_SVH
`define PACKBITS_RLE_DECODER_ASSERT_SVH

`ifndef SYNTH
`define PBRLE_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("pbrle assertion failed");
`define PBRLE_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("pbrle assertion failed");
`else
`define PBRLE_ASSERT_NOW(lbl, ant, con)
`define PBRLE_ASSERT_NEXT(lbl, ant, con)
`endif

`endif

// File: sv/pbrle_pkg.sv
package pbrle_pkg;

  localparam int PlaneW = 21;
  localparam logic [PlaneW-1:0] PlaneReset = 21'd8192;
  localparam logic [7:0] RunFlag = 8'h80;
  localparam logic [7:0] LowMask = 8'h7f;
  localparam logic [7:0] RunBias = 8'd3;
  localparam logic [7:0] LitBias = 8'd1;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_RUNVAL  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] repeat_res;
    logic       end_res;
    logic       ok;
  } out_item_t;

  typedef struct packed {
    phase_t            phase;
    logic [7:0]        literal_left;
    logic [7:0]        run_length;
    logic [PlaneW-1:0] bytes_written;
  } stream_t;

  typedef struct packed {
    stream_t   state_next;
    logic      res_valid;
    out_item_t res;
  } step_t;

endpackage

// File: sv/pbrle_step.sv
module pbrle_step (
  input  pbrle_pkg::stream_t                 state,
  input  pbrle_pkg::in_item_t                item,
  input  logic [pbrle_pkg::PlaneW-1:0]       limit,
  output pbrle_pkg::step_t                   step
);

  logic [pbrle_pkg::PlaneW-1:0] room;
  logic [pbrle_pkg::PlaneW-1:0] bw_run;
  logic [pbrle_pkg::PlaneW-1:0] bw_lit;
  logic [7:0]                   count;
  logic [7:0]                   lit_next;
  logic                         is_run;
  logic                         last;

  assign last     = item.last_byte;
  assign is_run   = (item.byte_in & pbrle_pkg::RunFlag) != 8'd0;
  assign count    = is_run ? (item.byte_in & pbrle_pkg::LowMask) + pbrle_pkg::RunBias
                           : item.byte_in + pbrle_pkg::LitBias;
  assign room     = (state.bytes_written < limit) ? limit - state.bytes_written
                                                  : '0;
  assign bw_run   = state.bytes_written + pbrle_pkg::PlaneW'(state.run_length);
  assign bw_lit   = state.bytes_written + pbrle_pkg::PlaneW'(1);
  assign lit_next = state.literal_left - 8'd1;

  always_comb begin
    step.state_next = state;
    step.res_valid  = 1'b0;
    step.res        = '{value: 8'd0, repeat_res: 8'd0, end_res: 1'b1, ok: 1'b0};
    case (state.phase)
      pbrle_pkg::PH_DISCARD: begin
        if (last) begin
          step.state_next = '{pbrle_pkg::PH_CONTROL, 8'd0, 8'd0, '0};
        end
      end
      pbrle_pkg::PH_RUNVAL: begin
        step.res_valid = 1'b1;
        step.res = '{value: item.byte_in, repeat_res: state.run_length,
                     end_res: last, ok: last && (bw_run == limit)};
        if (last) begin
          step.state_next = '{pbrle_pkg::PH_CONTROL, 8'd0, 8'd0, '0};
        end else begin
          step.state_next.phase         = pbrle_pkg::PH_CONTROL;
          step.state_next.run_length    = 8'd0;
          step.state_next.bytes_written = bw_run;
        end
      end
      pbrle_pkg::PH_LITERAL: begin
        step.res_valid = 1'b1;
        step.res = '{value: item.byte_in, repeat_res: 8'd1, end_res: last,
                     ok: last && (lit_next == 8'd0) && (bw_lit == limit)};
        if (last) begin
          step.state_next = '{pbrle_pkg::PH_CONTROL, 8'd0, 8'd0, '0};
        end else begin
          step.state_next.literal_left  = lit_next;
          step.state_next.bytes_written = bw_lit;
          if (lit_next == 8'd0) begin
            step.state_next.phase = pbrle_pkg::PH_CONTROL;
          end
        end
      end
      default: begin
        if (room == '0 || pbrle_pkg::PlaneW'(count) > room || last) begin
          // error verdict; close if final, else drop to the final byte
          step.res_valid = 1'b1;
          if (last) begin
            step.state_next = '{pbrle_pkg::PH_CONTROL, 8'd0, 8'd0, '0};
          end else begin
            step.state_next.phase        = pbrle_pkg::PH_DISCARD;
            step.state_next.literal_left = 8'd0;
            step.state_next.run_length   = 8'd0;
          end
        end else if (is_run) begin
          step.state_next.run_length = count;
          step.state_next.phase      = pbrle_pkg::PH_RUNVAL;
        end else begin
          step.state_next.literal_left = count;
          step.state_next.phase        = pbrle_pkg::PH_LITERAL;
        end
      end
    endcase
  end

endmodule

// File: sv/packbits_rle_decoder.sv
// Channel  Handshake          Payload
// in       in_valid/in_ready   in_data   (byte_in, last_byte)
// out      out_valid/out_ready out_data  (value, repeat_res, end_res, ok)
// cfg      psel/penable/pwrite paddr, pwdata, prdata (plane_bytes at 0x0)
// One byte per cycle sustained while out_ready is high; each item is decoded in the cycle it is taken.
// A result sits in the output register from the cycle after its item is taken.
// in_ready is high while the output register is empty or being drained.
// Synchronous reset clears the stream state and sets plane_bytes to 8192.
module packbits_rle_decoder #(
  parameter int unsigned MAX_PLANE_BYTES = 1048576
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pbrle_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pbrle_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

`include "packbits_rle_decoder_assert.svh"

  pbrle_pkg::stream_t             state;
  pbrle_pkg::step_t               step;
  logic [pbrle_pkg::PlaneW-1:0]   plane_bytes;
  logic [pbrle_pkg::PlaneW-1:0]   limit;
  logic                           in_fire;
  logic                           cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];
  assign prdata   = paddr[2] ? 32'd0 : 32'(plane_bytes);
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign limit    = (32'(plane_bytes) > MAX_PLANE_BYTES)
                  ? pbrle_pkg::PlaneW'(MAX_PLANE_BYTES) : plane_bytes;

  pbrle_step u_step (
    .state (state),
    .item  (in_data),
    .limit (limit),
    .step  (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '{pbrle_pkg::PH_CONTROL, 8'd0, 8'd0, '0};
      out_valid   <= 1'b0;
      plane_bytes <= pbrle_pkg::PlaneReset;
    end else begin
      if (cfg_wr) begin
        plane_bytes <= pwdata[pbrle_pkg::PlaneW-1:0];
      end
      if (in_fire) begin
        state <= step.state_next;
      end
      if (in_fire && step.res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step.res_valid) begin
      out_data <= step.res;
    end
  end

  `PBRLE_ASSERT_NOW(a_ok_needs_end, out_valid && out_data.ok, out_data.end_res)
  `PBRLE_ASSERT_NOW(a_verdict_only_fails, out_valid && (out_data.repeat_res == 8'd0),
                    out_data.end_res && !out_data.ok)
  `PBRLE_ASSERT_NEXT(a_runval_gives_run, in_fire && (state.phase == pbrle_pkg::PH_RUNVAL),
                     out_valid && (out_data.repeat_res != 8'd0))

endmodule

// File: tb/packbits_rle_decoder_tb.sv
module packbits_rle_decoder_tb;

  localparam int unsigned MaxPlane = 1048576;
  localparam logic [2:0] PlaneAddr = 3'd0;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned Limit = 1000000;
  localparam int unsigned RandomBytes = 900;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  pbrle_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  pbrle_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // decoder shadow state
  pbrle_pkg::phase_t ph = pbrle_pkg::PH_CONTROL;
  logic [7:0] lit_left = '0;
  logic [7:0] run_len = '0;
  int unsigned written = 0;
  logic [pbrle_pkg::PlaneW-1:0] plane_reg = pbrle_pkg::PlaneReset;

  pbrle_pkg::out_item_t pending_out[$];
  bit no_gaps = 1'b0;
  int unsigned errors = 0;
  int unsigned live_bytes = 0;
  int unsigned sent_bytes = 0;
  int unsigned streams_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  packbits_rle_decoder #(
    .MAX_PLANE_BYTES(MaxPlane)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_stream();
    ph = pbrle_pkg::PH_CONTROL;
    lit_left = '0;
    run_len = '0;
    written = 0;
  endfunction

  function automatic bit decode_byte(input pbrle_pkg::in_item_t it,
                                     output pbrle_pkg::out_item_t res);
    int unsigned limit;
    int unsigned room;
    int unsigned count;
    limit = (plane_reg > MaxPlane) ? MaxPlane : plane_reg;
    room = (written < limit) ? limit - written : 0;
    res = '0;
    case (ph)
      pbrle_pkg::PH_DISCARD: begin
        if (it.last_byte) clear_stream();
        return 1'b0;
      end
      pbrle_pkg::PH_RUNVAL: begin
        written += run_len;
        res.value = it.byte_in;
        res.repeat_res = run_len;
        if (it.last_byte) begin
          res.end_res = 1'b1;
          res.ok = (written == limit);
          clear_stream();
        end else begin
          ph = pbrle_pkg::PH_CONTROL;
          run_len = '0;
        end
        return 1'b1;
      end
      pbrle_pkg::PH_LITERAL: begin
        written += 1;
        lit_left = lit_left - 8'd1;
        res.value = it.byte_in;
        res.repeat_res = 8'd1;
        if (it.last_byte) begin
          res.end_res = 1'b1;
          res.ok = (lit_left == 0) && (written == limit);
          clear_stream();
        end else if (lit_left == 0) begin
          ph = pbrle_pkg::PH_CONTROL;
        end
        return 1'b1;
      end
      default: begin
        if ((it.byte_in & pbrle_pkg::RunFlag) != 0)
          count = 32'(it.byte_in & pbrle_pkg::LowMask) + 32'(pbrle_pkg::RunBias);
        else
          count = 32'(it.byte_in) + 32'(pbrle_pkg::LitBias);
        if (room == 0 || count > room || it.last_byte) begin
          res.end_res = 1'b1;
          if (it.last_byte) begin
            clear_stream();
          end else begin
            ph = pbrle_pkg::PH_DISCARD;
            lit_left = '0;
            run_len = '0;
          end
          return 1'b1;
        end
        if ((it.byte_in & pbrle_pkg::RunFlag) != 0) begin
          run_len = count[7:0];
          ph = pbrle_pkg::PH_RUNVAL;
        end else begin
          lit_left = count[7:0];
          ph = pbrle_pkg::PH_LITERAL;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    pbrle_pkg::in_item_t it;
    pbrle_pkg::out_item_t res;
    int gap;
    it.byte_in = b;
    it.last_byte = lst;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    if (ph != pbrle_pkg::PH_DISCARD) live_bytes++;
    if (decode_byte(it, res)) pending_out.push_back(res);
    if (lst) streams_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic plane_write(input logic [pbrle_pkg::PlaneW-1:0] v);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PlaneAddr;
    pwdata <= {11'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    plane_reg = v;
  endtask

  // long runs to cover n bytes exactly, closing the stream on the last value
  task automatic fill_runs(input int unsigned n);
    int unsigned left;
    int unsigned len;
    int unsigned k;
    left = n;
    while (left > 0) begin
      if (left < 3) begin
        send_byte(8'(left - 1), 1'b0);
        for (k = 0; k < left; k++) send_byte(8'($urandom), k == left - 1);
        left = 0;
      end else begin
        if (left > 130) len = (left - 130 < 3) ? 128 : 130;
        else len = left;
        send_byte(pbrle_pkg::RunFlag | 8'(len - 3), 1'b0);
        left -= len;
        send_byte(8'($urandom), left == 0);
      end
    end
  endtask

  task automatic send_stream(input int unsigned target);
    int unsigned left;
    int unsigned len;
    int unsigned cap;
    int unsigned k;
    left = target;
    if (target == 0) begin
      send_byte(8'($urandom), 1'b1);
      return;
    end
    while (left > 0) begin
      if (left >= 3 && $urandom_range(0, 1) == 1) begin
        cap = (left < 130) ? left : 130;
        case ($urandom_range(0, 3))
          0: len = 3;
          1: len = cap;
          default: len = $urandom_range(3, cap);
        endcase
        send_byte(pbrle_pkg::RunFlag | 8'(len - 3), 1'b0);
        left -= len;
        send_byte(8'($urandom), left == 0);
      end else begin
        cap = (left < 128) ? left : 128;
        case ($urandom_range(0, 3))
          0: len = 1;
          1: len = cap;
          default: len = $urandom_range(1, cap);
        endcase
        send_byte(8'(len - 1), 1'b0);
        for (k = 0; k < len; k++) begin
          left--;
          send_byte(8'($urandom), left == 0);
        end
      end
    end
  endtask

  task automatic send_noise(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++)
      send_byte(8'($urandom), k == n - 1 || $urandom_range(0, 7) == 0);
  endtask

  task automatic test_reset_plane();
    fill_runs(32'(pbrle_pkg::PlaneReset));
    settle();
  endtask

  task automatic test_corners();
    plane_write(21'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    // overrun, then discard to the final byte
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    // final control byte
    send_byte(8'h00, 1'b1);
    // control after a full plane
    send_byte(8'h00, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h99, 1'b1);

    plane_write(21'd16);
    send_byte(8'h03, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h8d, 1'b0);
    send_byte(8'h01, 1'b1);

    plane_write(21'd130);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);

    plane_write(21'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b1);
    settle();
  endtask

  // plane sizes at and beyond the block's maximum
  task automatic test_max_plane();
    plane_write(21'h1fffff);
    send_stream(120);
    settle();
    plane_write(21'(MaxPlane));
    send_stream(80);
    settle();
  endtask

  task automatic test_random();
    logic [pbrle_pkg::PlaneW-1:0] p;
    int unsigned target;
    int unsigned n;
    while (sent_bytes < RandomBytes) begin
      case ($urandom_range(0, 7))
        0: p = 21'($urandom_range(1, 8));
        1, 2, 3, 4: p = 21'($urandom_range(9, 120));
        5, 6: p = 21'($urandom_range(120, 300));
        default: p = 21'($urandom);
      endcase
      plane_write(p);
      for (n = 0; n < 6 && sent_bytes < RandomBytes; n++) begin
        if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
        if (p > 2000) target = $urandom_range(1, 150);
        else begin
          case ($urandom_range(0, 9))
            0: target = 0;
            1: target = p + $urandom_range(1, 5);
            2: target = $urandom_range(1, p);
            default: target = p;
          endcase
        end
        if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 12));
        else send_stream(target);
        if ($urandom_range(0, 9) == 0) settle();
      end
    end
    no_gaps = 1'b0;
    settle();
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  initial begin
    pbrle_pkg::out_item_t want;
    int gap;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_seen++;
      if (pending_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got %p", $time, out_data);
      end else begin
        want = pending_out.pop_front();
        check_field("value", want.value, out_data.value);
        check_field("repeat_res", want.repeat_res, out_data.repeat_res);
        check_field("end_res", 8'(want.end_res), 8'(out_data.end_res));
        check_field("ok", 8'(want.ok), 8'(out_data.ok));
      end
    end
  end

  initial begin
    while (cycles < Limit) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timed out with %0d items outstanding", $time, pending_out.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_plane();
    test_corners();
    test_max_plane();
    test_random();
    $display("Sent %0d bytes (%0d decodable) in %0d streams; %0d items checked in %0d cycles.",
             sent_bytes, live_bytes, streams_sent, results_seen, cycles);
    $display("Planes from 0 to beyond the maximum; runs, literals, overrun, truncation, discard.");
    if (errors == 0 && pending_out.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: packbits_rle_decoder.f
+incdir+sv
sv/pbrle_pkg.sv
sv/pbrle_step.sv
sv/packbits_rle_decoder.sv
tb/packbits_rle_decoder_tb.sv
